// ===== sv/gfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Glyph framebuffer renderer package
// Shared types, the command format passed from front to back, and the
// 5x7 font table with its lookup helpers.
// -----------------------------------------------------------------------------
package gfr_pkg;

	// Default screen geometry.
	localparam int SCREEN_COLS_DEF = 128;
	localparam int SCREEN_ROWS_DEF = 64;

	// Depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Font coverage.
	localparam int FIRST_CODE  = 32;
	localparam int LAST_CODE   = 90;
	localparam int GLYPH_COUNT = LAST_CODE - FIRST_CODE + 1;

	// Action codes as they arrive on the input channel.
	typedef enum logic [1:0] {
		ACT_DRAW  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// Five glyph columns, leftmost column in the top byte.
	typedef logic [39:0] glyph_t;

	// Classified command held in the queue.
	typedef struct packed {
		action_t     op;
		glyph_t      glyph;
		logic        big;
		logic [8:0]  x0;
		logic [7:0]  y0;
		logic [9:0]  read_index;
	} cmd_t;

	// Status from the back end to the front end.
	typedef struct packed {
		logic init_busy;
	} status_t;

	// Font table: each entry is columns 0..4, bit 0 of each column is the top row.
	localparam glyph_t GLYPH_ROM [GLYPH_COUNT] = '{
		40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
		40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
		40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
		40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
		40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
		40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
		40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
		40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
		40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
		40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
		40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
		40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
		40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
		40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
		40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43
	};

	// Font lookup; codes outside the font map to the blank glyph.
	function automatic glyph_t glyph_lookup(input logic [7:0] code);
		logic [5:0] sel;
		sel = '0;
		if (code >= 8'(FIRST_CODE) && code <= 8'(LAST_CODE))
			sel = 6'(code - 8'(FIRST_CODE));
		return GLYPH_ROM[sel];
	endfunction

	// Seven pixel bits of one glyph column.
	function automatic logic [6:0] glyph_column(input glyph_t g, input logic [2:0] idx);
		case (idx)
			3'd0: return g[38:32];
			3'd1: return g[30:24];
			3'd2: return g[22:16];
			3'd3: return g[14:8];
			3'd4: return g[6:0];
			default: return '0;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== sv/gfr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer that decouples the front end from the
// back end, so that either side can stall on its own.
// -----------------------------------------------------------------------------
module gfr_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire gfr_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output gfr_pkg::cmd_t      head
);

	localparam int DEPTH = gfr_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	gfr_pkg::cmd_t    slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full       = (count_q == (PTR_W+1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];

	// Storage is written on every push transfer.
	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_cmd;
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== sv/gfr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Front end
// Accepts items from the input channel, classifies the action and fetches
// the glyph from the font table, then pushes a command into the queue.
// -----------------------------------------------------------------------------
module gfr_front (
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       action,
	input  wire logic [8:0]       pos_x,
	input  wire logic [7:0]       pos_y,
	input  wire logic [7:0]       char_code,
	input  wire logic             double_size,
	input  wire logic [9:0]       read_index,
	input  wire logic             q_full,
	input  wire gfr_pkg::status_t status,
	output logic                  push,
	output gfr_pkg::cmd_t         push_cmd
);

	// Items are held off while the queue is full or the store is being cleared
	// after reset.
	assign in_ready = !q_full && !status.init_busy;
	assign push     = in_valid && in_ready;

	// Classification and font lookup.
	always_comb begin
		push_cmd.op         = gfr_pkg::action_t'(action);
		push_cmd.glyph      = gfr_pkg::glyph_lookup(char_code);
		push_cmd.big        = double_size;
		push_cmd.x0         = pos_x;
		push_cmd.y0         = pos_y;
		push_cmd.read_index = read_index;
	end

endmodule
`default_nettype wire

// ===== sv/gfr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Back end
// Executes queued commands against the framebuffer memory: glyph drawing by
// pipelined read-modify-write, clearing by a sweep, and byte reads. Holds
// the output register of the result channel.
// -----------------------------------------------------------------------------
module gfr_back #(
	parameter int SCREEN_COLS = gfr_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = gfr_pkg::SCREEN_ROWS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire gfr_pkg::cmd_t q_head,
	output logic               q_pop,
	output gfr_pkg::status_t   status,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         read_data
);

	localparam int PAGES       = (SCREEN_ROWS + 7) / 8;
	localparam int STORE_BYTES = SCREEN_COLS * PAGES;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int LAST_ROWS   = SCREEN_ROWS - 8 * (PAGES - 1);
	localparam logic [7:0] LAST_MASK = 8'((1 << LAST_ROWS) - 1);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DRAW,
		ST_DRAIN,
		ST_CLEAR,
		ST_READ,
		ST_DONE
	} state_t;

	state_t        state_q;
	gfr_pkg::cmd_t cmd_q;
	logic [3:0]    strip_q;
	logic [1:0]    part_q;
	logic [AW-1:0] sweep_q;
	logic          wr_valid_s2;
	logic [AW-1:0] wr_addr_s2;
	logic [7:0]    wr_mask_s2;
	logic          out_valid_q;
	logic [7:0]    read_data_q;

	// Framebuffer memory.
	logic [7:0]    frame_mem [STORE_BYTES];
	logic [7:0]    mem_rdata_q;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;

	// Per-step geometry of the draw sequencer.
	logic [2:0]         gidx;
	logic [6:0]         cbits;
	logic [13:0]        pattern;
	logic [23:0]        shifted;
	logic [7:0]         strip_bits;
	logic signed [5:0]  page;
	logic signed [10:0] col;
	logic               col_ok;
	logic               page_ok;
	logic [7:0]         row_mask;
	logic [7:0]         step_mask;
	logic               step_hit;
	logic [AW:0]        addr_w;
	logic [AW-1:0]      step_addr;
	logic [3:0]         last_strip;
	logic [1:0]         last_part;
	logic               sweep_active;
	logic               read_ok;
	logic [7:0]         res_data;
	logic               out_load;

	// One step covers one screen column and one page of the glyph strip.
	always_comb begin
		gidx  = cmd_q.big ? strip_q[3:1] : strip_q[2:0];
		cbits = gfr_pkg::glyph_column(cmd_q.glyph, gidx);
		if (cmd_q.big) begin
			for (int i = 0; i < 7; i++) begin
				pattern[2*i]   = cbits[i];
				pattern[2*i+1] = cbits[i];
			end
		end else begin
			pattern = {7'd0, cbits};
		end
		shifted = {10'd0, pattern} << cmd_q.y0[2:0];
		case (part_q)
			2'd0:    strip_bits = shifted[7:0];
			2'd1:    strip_bits = shifted[15:8];
			2'd2:    strip_bits = shifted[23:16];
			default: strip_bits = 8'h00;
		endcase
		page     = $signed({cmd_q.y0[7], cmd_q.y0[7:3]}) + $signed({4'd0, part_q});
		col      = $signed({{2{cmd_q.x0[8]}}, cmd_q.x0}) + $signed({7'd0, strip_q});
		col_ok   = !col[10] && (col[9:0] < 10'(SCREEN_COLS));
		page_ok  = !page[5] && (page[4:0] < 5'(PAGES));
		row_mask = (page[4:0] == 5'(PAGES - 1)) ? LAST_MASK : 8'hFF;
		step_mask = strip_bits & row_mask;
		step_hit  = col_ok && page_ok && (step_mask != 8'h00);
		addr_w    = (AW+1)'(col[9:0]) + (AW+1)'(page[4:0]) * (AW+1)'(SCREEN_COLS);
		step_addr = addr_w[AW-1:0];
		last_strip = cmd_q.big ? 4'd9 : 4'd4;
		last_part  = cmd_q.big ? 2'd2 : 2'd1;
	end

	// Memory port selection.
	always_comb begin
		sweep_active = (state_q == ST_INIT) || (state_q == ST_CLEAR);
		read_ok      = (32'(cmd_q.read_index) < STORE_BYTES);
		mem_re       = (state_q == ST_READ) || ((state_q == ST_DRAW) && step_hit);
		mem_raddr    = (state_q == ST_READ) ? AW'(cmd_q.read_index) : step_addr;
		mem_we       = sweep_active || wr_valid_s2;
		mem_waddr    = sweep_active ? sweep_q : wr_addr_s2;
		mem_wdata    = sweep_active ? 8'h00 : (mem_rdata_q | wr_mask_s2);
		res_data     = ((cmd_q.op == gfr_pkg::ACT_READ) && read_ok) ? mem_rdata_q : 8'h00;
		out_load     = (state_q == ST_DONE) && (!out_valid_q || out_ready);
		q_pop        = (state_q == ST_IDLE) && q_valid;
		status.init_busy = (state_q == ST_INIT);
	end

	// Memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we)
			frame_mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			mem_rdata_q <= frame_mem[mem_raddr];
	end

	// Sequencer, write stage and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cmd_q       <= '0;
			strip_q     <= '0;
			part_q      <= '0;
			sweep_q     <= '0;
			wr_valid_s2 <= 1'b0;
			wr_addr_s2  <= '0;
			wr_mask_s2  <= '0;
			out_valid_q <= 1'b0;
			read_data_q <= '0;
		end else begin
			wr_valid_s2 <= (state_q == ST_DRAW) && step_hit;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_INIT, ST_CLEAR: begin
					if (sweep_q == AW'(STORE_BYTES - 1)) begin
						sweep_q <= '0;
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end

				ST_IDLE: begin
					if (q_valid) begin
						cmd_q   <= q_head;
						strip_q <= '0;
						part_q  <= '0;
						sweep_q <= '0;
						case (q_head.op)
							gfr_pkg::ACT_DRAW:  state_q <= ST_DRAW;
							gfr_pkg::ACT_CLEAR: state_q <= ST_CLEAR;
							gfr_pkg::ACT_READ:  state_q <= ST_READ;
							default:            state_q <= ST_DONE;
						endcase
					end
				end

				ST_DRAW: begin
					// Read issued this cycle, merge and write back next cycle.
					wr_addr_s2  <= step_addr;
					wr_mask_s2  <= step_mask;
					if (part_q == last_part) begin
						part_q <= '0;
						if (strip_q == last_strip)
							state_q <= ST_DRAIN;
						else
							strip_q <= strip_q + 1'b1;
					end else begin
						part_q <= part_q + 1'b1;
					end
				end

				ST_DRAIN: begin
					state_q <= ST_DONE;
				end

				ST_READ: begin
					state_q <= ST_DONE;
				end

				ST_DONE: begin
					if (out_load) begin
						read_data_q <= res_data;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule
`default_nettype wire

// ===== sv/glyph_framebuffer_renderer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Glyph framebuffer renderer
// Monochrome page-layout framebuffer with a 5x7 character generator.
//
// Each transfer on the input channel carries one action: draw a character
// (optionally at double size, clipped at the screen edges), clear the whole
// framebuffer, or read one framebuffer byte. Every item gives exactly one
// transfer on the output channel; read_data is the byte for a read and zero
// otherwise, also for a read beyond the store. Results leave in the order items were taken.
// A front end takes items into a two-entry command queue; the back end runs
// them against a single-port-write, single-port-read memory.
// Work per item in the back end: a read is one memory read, a normal draw
// 10 read-modify-write steps, a double-size draw 30 steps, and a clear a
// sweep of every store byte (1024 by default).
// A draw step with pixels on screen is one pipelined memory read and merged
// write-back. After reset the store is swept to zero, one byte a cycle, with
// in_ready low. When the receiver stalls, the result waits in the output
// register and further items fill the queue before in_ready drops.
// -----------------------------------------------------------------------------
module glyph_framebuffer_renderer #(
	parameter int SCREEN_COLS = gfr_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = gfr_pkg::SCREEN_ROWS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        action,
	input  wire logic signed [8:0] pos_x,
	input  wire logic signed [7:0] pos_y,
	input  wire logic [7:0]        char_code,
	input  wire logic              double_size,
	input  wire logic [9:0]        read_index,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             read_data
);

	logic             q_full;
	logic             push;
	gfr_pkg::cmd_t    push_cmd;
	logic             q_pop;
	logic             q_valid;
	gfr_pkg::cmd_t    q_head;
	gfr_pkg::status_t status;

	// Front end: accept and classify.
	gfr_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.char_code   (char_code),
		.double_size (double_size),
		.read_index  (read_index),
		.q_full      (q_full),
		.status      (status),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	// Command queue between the two halves.
	gfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	// Back end: memory work and result register.
	gfr_back #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data)
	);

endmodule
`default_nettype wire

// ===== sv/gfr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Port checker
// Watches the top-level channels: result count against accepted items,
// the bound on items in flight, start-up behaviour and output stability.
// -----------------------------------------------------------------------------
module gfr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] read_data
);

	localparam int LIMIT = gfr_pkg::QUEUE_DEPTH + 2;
	localparam int CW    = $clog2(LIMIT + 1);

	logic [CW-1:0] pending_q;

	// Items accepted whose result has not yet been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			if ((in_valid && in_ready) && !(out_valid && out_ready))
				pending_q <= pending_q + 1'b1;
			else if (!(in_valid && in_ready) && (out_valid && out_ready))
				pending_q <= pending_q - 1'b1;
		end
	end

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data))
		else $error("result changed or dropped while stalled");

	// No result appears without an accepted item behind it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result offered with no item in flight");

	// The block stops taking items once every buffer is occupied.
	a_flight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q >= CW'(LIMIT) |-> !in_ready)
		else $error("item accepted beyond buffering capacity");

	// Straight after reset the store is being cleared: nothing taken or given.
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !in_ready && !out_valid)
		else $error("channel active right after reset");

endmodule

bind glyph_framebuffer_renderer gfr_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.read_data (read_data)
);
`default_nettype wire
